// ===== hw/rtl/kxor_pkg.sv =====
// Shared types, constants and helper functions for the keystream XOR core.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps
package kxor_pkg;

	localparam int NONCE_BYTES = 16;
	localparam int NONCE_USED = (NONCE_BYTES > 16) ? 16 : NONCE_BYTES;
	localparam int KEY_LEN = 32;
	localparam int SEED_FIXED = 36;
	localparam int SEED_BYTES = SEED_FIXED + NONCE_USED;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_start;
	} kxor_item_t;

	typedef struct packed {
		logic         start;
		logic [511:0] block;
	} kxor_sha_req_t;

	typedef struct packed {
		logic         done;
		logic [255:0] digest;
	} kxor_sha_rsp_t;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Padding tail of a chained block: 32 message bytes, 0x80, length of 256 bits.
	localparam logic [255:0] CHAIN_PAD = {8'h80, 232'h0, 16'h0100};

	// Padded single-block message: key, key id and nonce, all little-endian.
	function automatic logic [511:0] seed_message(input logic [255:0] key,
			input logic [31:0] key_id, input logic [127:0] nonce);
		logic [511:0] m;
		int k;
		m = '0;
		for (k = 0; k < KEY_LEN; k++) begin
			m[511 - 8 * k -: 8] = key[8 * k +: 8];
		end
		for (k = 0; k < 4; k++) begin
			m[511 - 8 * (KEY_LEN + k) -: 8] = key_id[8 * k +: 8];
		end
		for (k = 0; k < NONCE_USED; k++) begin
			m[511 - 8 * (SEED_FIXED + k) -: 8] = nonce[8 * k +: 8];
		end
		m[511 - 8 * SEED_BYTES -: 8] = 8'h80;
		m[15:0] = 16'(SEED_BYTES * 8);
		return m;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== hw/rtl/kxor_front.sv =====
// Input side of the keystream XOR core: accepts items into a short queue.
// Depends on kxor_pkg.
`timescale 1ns / 1ps
module kxor_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kxor_pkg::kxor_item_t in_item,
	output logic              head_valid,
	output kxor_pkg::kxor_item_t head_item,
	input  logic              pop
);
	import kxor_pkg::*;

	kxor_item_t          slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                push;

	assign in_ready   = (count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/kxor_sha.sv =====
// SHA-256 compression of one padded block, one round per cycle.
// Depends on kxor_pkg.
`timescale 1ns / 1ps
module kxor_sha (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kxor_pkg::kxor_sha_req_t req,
	output kxor_pkg::kxor_sha_rsp_t rsp
);
	import kxor_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [31:0] st_q [8];
	logic [31:0] w_q [16];
	logic [255:0] dig_q;
	logic [31:0] t1, t2, w_new;
	logic [31:0] s0, s1;
	int i;

	always_comb begin
		t1 = st_q[7] + (rotr(st_q[4], 6) ^ rotr(st_q[4], 11) ^ rotr(st_q[4], 25))
			+ ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6])) + SHA_K[cnt_q[5:0]] + w_q[0];
		t2 = (rotr(st_q[0], 2) ^ rotr(st_q[0], 13) ^ rotr(st_q[0], 22))
			+ ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			for (i = 0; i < 8; i++) begin
				st_q[i] <= SHA_IV[i];
			end
			for (i = 0; i < 16; i++) begin
				w_q[i] <= req.block[511 - 32 * i -: 32];
			end
		end else if (busy_q && !cnt_q[6]) begin
			st_q[0] <= t1 + t2;
			st_q[1] <= st_q[0];
			st_q[2] <= st_q[1];
			st_q[3] <= st_q[2];
			st_q[4] <= st_q[3] + t1;
			st_q[5] <= st_q[4];
			st_q[6] <= st_q[5];
			st_q[7] <= st_q[6];
			for (i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (busy_q && cnt_q[6]) begin
			for (i = 0; i < 8; i++) begin
				dig_q[255 - 32 * i -: 32] <= SHA_IV[i] + st_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q[6]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.digest = dig_q;

endmodule

// ===== hw/rtl/kxor_back.sv =====
// Execution side: keystream block, byte position, hash sequencing, output register.
// Depends on kxor_pkg; drives kxor_sha through its request struct.
`timescale 1ns / 1ps
module kxor_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  kxor_pkg::kxor_item_t   head_item,
	output logic                   pop,
	input  logic [511:0]           seed_block,
	output kxor_pkg::kxor_sha_req_t sha_req,
	input  kxor_pkg::kxor_sha_rsp_t sha_rsp,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte
);
	import kxor_pkg::*;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_SEED  = 2'd1;
	localparam logic [1:0] ST_CHAIN = 2'd2;

	logic [1:0]   state_q;
	logic [255:0] ks_q;
	logic [4:0]   pos_q;
	logic         seeded_q;
	logic         out_valid_q;
	logic [7:0]   out_byte_q;
	logic         slot_free, take, need_seed;
	logic [4:0]   ks_idx;

	assign slot_free = !out_valid_q || out_ready;
	assign need_seed = (state_q == ST_RUN) && head_valid && head_item.region_start && !seeded_q;
	assign take      = (state_q == ST_RUN) && head_valid && slot_free
		&& (!head_item.region_start || seeded_q);
	assign pop       = take;
	assign ks_idx    = 5'd31 - pos_q;

	assign sha_req.start = need_seed || (take && (pos_q == 5'd31));
	assign sha_req.block = need_seed ? seed_block : {ks_q, CHAIN_PAD};

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= head_item.data_byte ^ ks_q[{ks_idx, 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			ks_q        <= '0;
			pos_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (need_seed) begin
						state_q <= ST_SEED;
					end else if (take) begin
						seeded_q <= 1'b0;
						pos_q    <= pos_q + 1'b1;
						if (pos_q == 5'd31) begin
							state_q <= ST_CHAIN;
						end
					end
				end
				ST_SEED: begin
					if (sha_rsp.done) begin
						ks_q     <= sha_rsp.digest;
						pos_q    <= '0;
						seeded_q <= 1'b1;
						state_q  <= ST_RUN;
					end
				end
				ST_CHAIN: begin
					if (sha_rsp.done) begin
						ks_q    <= sha_rsp.digest;
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule

// ===== hw/rtl/hash_chain_keystream_xor_core.sv =====
// Keystream XOR core: when no hash is due, an accepted byte is stored in the queue and its
// result is then registered in the output register. A region start or every 32nd byte costs
// one SHA-256 compression, one round per cycle in the shared hash unit, while no byte leaves the queue.
// A four-item queue keeps accepting, until it is full, while the hash unit runs or the output stalls.
// Reset clears the registers, the keystream block to zero and all control state.
`timescale 1ns / 1ps
module hash_chain_keystream_xor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        region_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte
);
	import kxor_pkg::*;

	// Register indexes; each register occupies eight bytes of address space.
	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_KEY_ID = 3'd4;
	localparam logic [2:0] REG_NONCE0 = 3'd5;
	localparam logic [2:0] REG_NONCE1 = 3'd6;

	logic [63:0] key_q [4];
	logic [31:0] key_id_q;
	logic [63:0] nonce_lo_q;
	logic [63:0] nonce_hi_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	kxor_item_t    in_item, head_item;
	logic          head_valid, pop;
	kxor_sha_req_t sha_req;
	kxor_sha_rsp_t sha_rsp;
	logic [511:0]  seed_block;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;

	// Register file. Writes to indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0]   <= '0;
			key_q[1]   <= '0;
			key_q[2]   <= '0;
			key_q[3]   <= '0;
			key_id_q   <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KEY0:   key_q[0]   <= pwdata;
				REG_KEY1:   key_q[1]   <= pwdata;
				REG_KEY2:   key_q[2]   <= pwdata;
				REG_KEY3:   key_q[3]   <= pwdata;
				REG_KEY_ID: key_id_q   <= pwdata[31:0];
				REG_NONCE0: nonce_lo_q <= pwdata;
				REG_NONCE1: nonce_hi_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KEY0:   prdata = key_q[0];
			REG_KEY1:   prdata = key_q[1];
			REG_KEY2:   prdata = key_q[2];
			REG_KEY3:   prdata = key_q[3];
			REG_KEY_ID: prdata = {32'h0, key_id_q};
			REG_NONCE0: prdata = nonce_lo_q;
			REG_NONCE1: prdata = nonce_hi_q;
			default:    prdata = '0;
		endcase
	end

	// The seed message is formed from the registers as they stand when a region starts.
	assign seed_block = seed_message({key_q[3], key_q[2], key_q[1], key_q[0]}, key_id_q,
		{nonce_hi_q, nonce_lo_q});

	assign in_item.data_byte    = data_byte;
	assign in_item.region_start = region_start;

	kxor_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	kxor_sha u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sha_req),
		.rsp    (sha_rsp)
	);

	// The back end holds the keystream block and byte position, starts a hash for a
	// region start or after the last byte of a block, and owns the output register.
	kxor_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.seed_block (seed_block),
		.sha_req    (sha_req),
		.sha_rsp    (sha_rsp),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte)
	);

endmodule

// ===== tb/sv/hash_chain_keystream_xor_core_tb.sv =====
// Self-checking testbench for the hash-chained keystream XOR core.
// Depends on kxor_pkg and hash_chain_keystream_xor_core; predicts every output byte itself.
`timescale 1ns / 1ps
module hash_chain_keystream_xor_core_tb;
	import kxor_pkg::*;

	// Register indexes; each register sits at byte address 8 * index.
	typedef enum int {
		REG_KEY0 = 0, REG_KEY1 = 1, REG_KEY2 = 2, REG_KEY3 = 3,
		REG_KEY_ID = 4, REG_NONCE_LO = 5, REG_NONCE_HI = 6
	} reg_index_e;

	localparam int CHAIN_MSG_LEN = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 200;

	// Predictor of the cipher and store of expected output bytes.
	class keystream_board;
		logic [63:0] key [4];
		logic [31:0] key_id;
		logic [63:0] nonce_lo, nonce_hi;
		logic [255:0] ks_block;
		logic [4:0] pos;
		logic [7:0] pending_bytes [$];
		int mismatches;
		int checked;

		function new();
			foreach (key[i]) key[i] = '0;
			key_id = '0;
			nonce_lo = '0;
			nonce_hi = '0;
			ks_block = '0;
			pos = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(reg_index_e idx, logic [63:0] v);
			case (idx)
				REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key[int'(idx)] = v;
				REG_KEY_ID: key_id = v[31:0];
				REG_NONCE_LO: nonce_lo = v;
				REG_NONCE_HI: nonce_hi = v;
				default: ;
			endcase
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// SHA-256 of a short message held as bytes; the result is kept little-endian,
		// digest byte 0 in the least significant position.
		function logic [255:0] digest_of(logic [7:0] msg [], int len);
			logic [7:0] blk [64];
			logic [31:0] w [64];
			logic [31:0] h [8];
			logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
			logic [63:0] bits;
			logic [255:0] r;
			for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg[i] : 8'h00;
			blk[len] = 8'h80;
			bits = 64'(len) * 8;
			for (int i = 0; i < 8; i++) blk[63 - i] = bits[8 * i +: 8];
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
			for (int i = 16; i < 64; i++) begin
				s0 = ror(w[i - 15], 7) ^ ror(w[i - 15], 18) ^ (w[i - 15] >> 3);
				s1 = ror(w[i - 2], 17) ^ ror(w[i - 2], 19) ^ (w[i - 2] >> 10);
				w[i] = w[i - 16] + s0 + w[i - 7] + s1;
			end
			h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			a = h[0]; b = h[1]; c = h[2]; d = h[3];
			e = h[4]; f = h[5]; g = h[6]; hh = h[7];
			for (int i = 0; i < 64; i++) begin
				t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
					+ SHA_K[i] + w[i];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				hh = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			h[0] += a; h[1] += b; h[2] += c; h[3] += d;
			h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
			for (int i = 0; i < 8; i++)
				for (int j = 0; j < 4; j++)
					r[8 * (4 * i + j) +: 8] = h[i][31 - 8 * j -: 8];
			return r;
		endfunction

		// Notes an accepted byte and queues the byte the core must return for it.
		function void note_input(logic [7:0] data, logic start);
			logic [7:0] msg [];
			if (start) begin
				msg = new[SEED_BYTES];
				for (int i = 0; i < KEY_LEN; i++) msg[i] = key[i / 8][8 * (i % 8) +: 8];
				for (int i = 0; i < 4; i++) msg[KEY_LEN + i] = key_id[8 * i +: 8];
				for (int i = 0; i < NONCE_USED; i++)
					msg[SEED_FIXED + i] = (i < 8) ? nonce_lo[8 * i +: 8]
						: nonce_hi[8 * (i - 8) +: 8];
				ks_block = digest_of(msg, SEED_BYTES);
				pos = '0;
			end
			pending_bytes.push_back(data ^ ks_block[8 * pos +: 8]);
			pos = pos + 5'd1;
			if (pos == 5'd0) begin
				msg = new[CHAIN_MSG_LEN];
				for (int i = 0; i < CHAIN_MSG_LEN; i++) msg[i] = ks_block[8 * i +: 8];
				ks_block = digest_of(msg, CHAIN_MSG_LEN);
			end
		endfunction

		function void check_output(logic [7:0] got);
			logic [7:0] want;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output byte %02h with nothing pending", got);
				return;
			end
			want = pending_bytes.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("out_byte mismatch: expected %02h, got %02h", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic region_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;

	keystream_board board = new();
	int idle_cycles = 0;
	bit timed_out = 1'b0;
	bit calm = 1'b0;
	int sent = 0;
	int regions = 0;

	always #5 clk = ~clk;

	hash_chain_keystream_xor_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .region_start(region_start),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte)
	);

	// Outputs are sampled at the rising edge, before any nonblocking update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) board.check_output(out_byte);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// The receiver stalls in random bursts, except in the calm tail of the run.
	initial begin
		int hold;
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// The watchdog ends the run when nothing moves for too long.
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		timed_out = 1'b1;
	end

	// APB write: a setup phase, then an access phase; the register takes the value at
	// the edge that closes the access phase. The bus then returns to idle before the task ends.
	task automatic apb_write(reg_index_e idx, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(8 * int'(idx));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.write_reg(idx, v);
		@(posedge clk);
	endtask

	// Sends one item, with a random idle burst first unless the run is in its calm tail.
	// Valid stays high afterwards so that the next item can follow at once.
	task automatic send_byte(logic [7:0] d, logic s);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		region_start <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(d, s);
		sent++;
		if (s) regions++;
	endtask

	// A region of the given length, the first byte marked as its start.
	task automatic send_region(int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), i == 0);
	endtask

	// Stops sending, then waits until every expected byte has returned and the core
	// has settled, so the registers can be rewritten safely.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_bytes.size() != 0 && !timed_out) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_all(logic [63:0] v [7]);
		for (int i = 0; i < 7; i++) apb_write(reg_index_e'(i), v[i]);
	endtask

	task automatic run_stimulus();
		logic [63:0] v [7];
		int len;
		// Bytes before any region start use the all-zero keystream, then its chain;
		// 40 of them cross one block boundary.
		for (int i = 0; i < 40; i++) send_byte((i % 2) ? 8'hff : 8'h00, 1'b0);
		drain();
		// All-ones registers: the widest values of every field.
		foreach (v[i]) v[i] = '1;
		write_all(v);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h5a, 1'b1);
		// A register written in mid-region only takes hold at the next region start.
		drain();
		apb_write(REG_KEY_ID, 64'h0000_0000_1234_5678);
		send_byte(8'ha5, 1'b0);
		send_byte(8'h3c, 1'b1);
		// Pause the sender until every expected byte is back.
		drain();
		// A register index beyond the map is simply ignored by the core.
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 6'd56; pwdata <= '1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		send_byte(8'h81, 1'b1);
		drain();
		// Random phases: fresh registers each time, all-zero once, then regions of
		// mostly short length with the odd long one spanning two to four blocks.
		for (int phase = 0; phase < 6; phase++) begin
			foreach (v[i]) v[i] = (phase == 2) ? 64'h0 : {$urandom, $urandom};
			write_all(v);
			while (sent < 30 + (phase + 1) * 210) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 100)
					: $urandom_range(1, 34);
				if ($urandom_range(0, 7) == 0) begin
					// A stray byte that keeps the running chain going.
					send_byte(8'($urandom), 1'b0);
				end else begin
					send_region(len);
				end
			end
			drain();
			if (phase == 4) calm = 1'b1;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			run_stimulus();
			wait (timed_out);
		join_any
		disable fork;
		if (!timed_out) drain();
		$display("Sent %0d bytes in %0d regions, %0d output bytes checked.",
			sent, regions, board.checked);
		if (timed_out) begin
			$display("[hash_chain_keystream_xor_core] ERROR");
		end else if (board.mismatches == 0 && board.pending_bytes.size() == 0) begin
			$display("[hash_chain_keystream_xor_core] OK");
		end else begin
			$display("[hash_chain_keystream_xor_core] ERROR");
		end
		$finish;
	end
endmodule
